>>> sv/tss_pkg.sv
// shared types, codes and lookup functions of the tuner start sequencer
`timescale 1ns / 1ps

package tss_pkg;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_QUERY  = 3'd1,
        PH_TSTART = 3'd2,
        PH_TUNING = 3'd3,
        PH_FIN1   = 3'd4,
        PH_FIN2   = 3'd5
    } t_phase;

    // transceiver reply kinds
    typedef enum logic [2:0] {
        REP_NONE     = 3'd0,
        REP_FUNCTION = 3'd1,
        REP_MODE     = 3'd2,
        REP_METER    = 3'd3,
        REP_POWER    = 3'd4,
        REP_OTHER    = 3'd5
    } t_reply;

    // messages the sequencer asks to be sent to the transceiver
    typedef enum logic [2:0] {
        SEND_NONE    = 3'd0,
        SEND_QUERY   = 3'd1,
        SEND_SETUP   = 3'd2,
        SEND_KEY_ON  = 3'd3,
        SEND_KEY_OFF = 3'd4
    } t_send;

    typedef enum logic [1:0] {
        OUT_NONE = 2'd0,
        OUT_OK   = 2'd1,
        OUT_FAIL = 2'd2,
        OUT_ERR  = 2'd3
    } t_outcome;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_REPLY_TIMEOUT = 3'd0,
        CFG_START_TIMEOUT = 3'd1,
        CFG_TUNE_TIMEOUT  = 3'd2,
        CFG_FINISH_WAIT   = 3'd3,
        CFG_PULSE_TIMEOUT = 3'd4
    } t_cfg_idx;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_DATA_BITS-1:0] RST_REPLY_TIMEOUT = 16'd500;
    localparam logic [CFG_DATA_BITS-1:0] RST_START_TIMEOUT = 16'd500;
    localparam logic [CFG_DATA_BITS-1:0] RST_TUNE_TIMEOUT  = 16'd10000;
    localparam logic [CFG_DATA_BITS-1:0] RST_FINISH_WAIT   = 16'd100;
    localparam logic [CFG_DATA_BITS-1:0] RST_PULSE_TIMEOUT = 16'd500;

    localparam logic [3:0] PEND_ALL = 4'hF;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] pulse_end_timeout_ms;
        logic [CFG_DATA_BITS-1:0] finish_wait_ms;
        logic [CFG_DATA_BITS-1:0] tune_limit_ms;
        logic [CFG_DATA_BITS-1:0] start_timeout_ms;
        logic [CFG_DATA_BITS-1:0] reply_timeout_ms;
    } t_cfg;

    // input transaction layout, last field in the lowest bits
    typedef struct packed {
        logic [6:0]  pad;
        logic        key_low;
        logic        jump_low;
        logic        start_request;
        logic [9:0]  txr_value;
        logic [2:0]  txr_reply;
        logic        pc_message_valid;
        logic [31:0] now_ms;
    } t_in_item;

    // output transaction layout, last field in the lowest bits
    typedef struct packed {
        logic [3:0] pad;
        logic [1:0] outcome;
        logic       led_on;
        logic       start_pin_low;
        logic [9:0] saved_power;
        logic [9:0] saved_meter;
        logic [3:0] saved_mode;
        logic [9:0] saved_function;
        logic       restore_now;
        logic [2:0] send_code;
        logic       forward_txr_to_pc;
        logic       forward_pc_to_txr;
    } t_out_item;

    // sequencer results handed to the output stage
    typedef struct packed {
        logic       fwd_pc;
        logic       fwd_txr;
        t_send      send;
        logic       restore;
        logic [9:0] keep_function;
        logic [3:0] keep_mode;
        logic [9:0] keep_meter;
        logic [9:0] keep_power;
        logic       start_low;
        t_outcome   result;
    } t_seq_out;

    function automatic logic [2:0] flash_count(input t_outcome code);
        case (code)
            OUT_OK:   flash_count = 3'd1;
            OUT_FAIL: flash_count = 3'd1;
            OUT_ERR:  flash_count = 3'd5;
            default:  flash_count = 3'd0;
        endcase
    endfunction

    function automatic logic [9:0] flash_len(input t_outcome code);
        case (code)
            OUT_OK:   flash_len = 10'd100;
            OUT_FAIL: flash_len = 10'd1000;
            OUT_ERR:  flash_len = 10'd100;
            default:  flash_len = 10'd0;
        endcase
    endfunction

endpackage

>>> sv/tss_sequencer.sv
// phase state machine: forwarding, settings query, start, tuning and finish waits
`timescale 1ns / 1ps

module tss_sequencer
    import tss_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  t_in_item             i_item,
    input  logic [TIME_BITS-1:0] i_now,
    input  t_cfg                 i_cfg,
    output t_seq_out             o_seq
);

    t_phase               r_phase, n_phase;
    logic [TIME_BITS-1:0] r_deadline, n_deadline;
    logic [3:0]           r_pending, n_pending;
    logic [9:0]           r_keep_function, n_keep_function;
    logic [3:0]           r_keep_mode, n_keep_mode;
    logic [9:0]           r_keep_meter, n_keep_meter;
    logic [9:0]           r_keep_power, n_keep_power;
    logic                 r_start_low, n_start_low;

    logic                 w_late;
    t_reply               w_rep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline      <= '0;
            r_pending       <= '0;
            r_keep_function <= '0;
            r_keep_mode     <= '0;
            r_keep_meter    <= '0;
            r_keep_power    <= '0;
            r_start_low     <= 1'b0;
        end else if (i_step) begin
            r_deadline      <= n_deadline;
            r_pending       <= n_pending;
            r_keep_function <= n_keep_function;
            r_keep_mode     <= n_keep_mode;
            r_keep_meter    <= n_keep_meter;
            r_keep_power    <= n_keep_power;
            r_start_low     <= n_start_low;
        end
    end

    // deadlines compare without wrap
    assign w_late = i_now > r_deadline;
    assign w_rep  = t_reply'(i_item.txr_reply);

    always_comb begin
        n_phase         = r_phase;
        n_deadline      = r_deadline;
        n_pending       = r_pending;
        n_keep_function = r_keep_function;
        n_keep_mode     = r_keep_mode;
        n_keep_meter    = r_keep_meter;
        n_keep_power    = r_keep_power;
        n_start_low     = r_start_low;
        o_seq.fwd_pc    = 1'b0;
        o_seq.fwd_txr   = 1'b0;
        o_seq.send      = SEND_NONE;
        o_seq.restore   = 1'b0;
        o_seq.result    = OUT_NONE;

        case (r_phase)
            PH_QUERY: begin
                case (w_rep)
                    REP_FUNCTION: begin
                        n_keep_function = i_item.txr_value;
                        n_pending[0]    = 1'b0;
                    end
                    REP_MODE: begin
                        n_keep_mode  = i_item.txr_value[3:0];
                        n_pending[1] = 1'b0;
                    end
                    REP_METER: begin
                        n_keep_meter = i_item.txr_value;
                        n_pending[2] = 1'b0;
                    end
                    REP_POWER: begin
                        n_keep_power = i_item.txr_value;
                        n_pending[3] = 1'b0;
                    end
                    default: ;
                endcase
                if (n_pending == '0) begin
                    o_seq.send  = SEND_SETUP;
                    n_start_low = 1'b1;
                    n_phase     = PH_TSTART;
                    n_deadline  = i_now + TIME_BITS'(i_cfg.start_timeout_ms);
                end else if (w_late) begin
                    // settings incomplete, nothing to restore
                    o_seq.result = OUT_ERR;
                    n_phase      = PH_IDLE;
                end
            end
            PH_TSTART: begin
                if (i_item.key_low) begin
                    n_start_low = 1'b0;
                    o_seq.send  = SEND_KEY_ON;
                    n_phase     = PH_TUNING;
                    n_deadline  = i_now + TIME_BITS'(i_cfg.tune_limit_ms);
                end else if (w_late) begin
                    n_start_low   = 1'b0;
                    o_seq.restore = 1'b1;
                    o_seq.result  = OUT_ERR;
                    n_phase       = PH_IDLE;
                end
            end
            PH_TUNING: begin
                if (!i_item.key_low) begin
                    o_seq.send = SEND_KEY_OFF;
                    n_phase    = PH_FIN1;
                    n_deadline = i_now + TIME_BITS'(i_cfg.finish_wait_ms);
                end else if (w_late) begin
                    o_seq.send    = SEND_KEY_OFF;
                    o_seq.restore = 1'b1;
                    o_seq.result  = OUT_ERR;
                    n_phase       = PH_IDLE;
                end
            end
            PH_FIN1: begin
                if (i_item.key_low) begin
                    // second key pulse marks a failed tune
                    n_phase    = PH_FIN2;
                    n_deadline = i_now + TIME_BITS'(i_cfg.pulse_end_timeout_ms);
                end else if (w_late) begin
                    o_seq.restore = 1'b1;
                    o_seq.result  = OUT_OK;
                    n_phase       = PH_IDLE;
                end
            end
            PH_FIN2: begin
                if (!i_item.key_low) begin
                    o_seq.restore = 1'b1;
                    o_seq.result  = OUT_FAIL;
                    n_phase       = PH_IDLE;
                end else if (w_late) begin
                    o_seq.restore = 1'b1;
                    o_seq.result  = OUT_ERR;
                    n_phase       = PH_IDLE;
                end
            end
            default: begin
                // idle, and any unused phase code
                o_seq.fwd_pc  = i_item.pc_message_valid;
                o_seq.fwd_txr = i_item.txr_reply != REP_NONE;
                if (i_item.start_request || i_item.jump_low) begin
                    n_phase    = PH_QUERY;
                    n_deadline = i_now + TIME_BITS'(i_cfg.reply_timeout_ms);
                    n_pending  = PEND_ALL;
                    o_seq.send = SEND_QUERY;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase

        o_seq.keep_function = n_keep_function;
        o_seq.keep_mode     = n_keep_mode;
        o_seq.keep_meter    = n_keep_meter;
        o_seq.keep_power    = n_keep_power;
        o_seq.start_low     = n_start_low;
    end

endmodule

>>> sv/tss_flasher.sv
// status led flasher loaded by an outcome and toggled on elapsed time
`timescale 1ns / 1ps

module tss_flasher
    import tss_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [TIME_BITS-1:0] i_now,
    input  t_outcome             i_result,
    output logic                 o_led
);

    logic [2:0]           r_left, n_left;
    logic                 r_led, n_led;
    logic [TIME_BITS-1:0] r_since, n_since;
    logic [9:0]           r_length, n_length;
    logic [TIME_BITS-1:0] w_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_led    <= 1'b0;
            r_since  <= '0;
            r_length <= '0;
        end else if (i_step) begin
            r_left   <= n_left;
            r_led    <= n_led;
            r_since  <= n_since;
            r_length <= n_length;
        end
    end

    always_comb begin
        n_left   = r_left;
        n_led    = r_led;
        n_since  = r_since;
        n_length = r_length;
        if (i_result != OUT_NONE) begin
            n_left   = flash_count(i_result);
            n_led    = 1'b1;
            n_since  = i_now;
            n_length = flash_len(i_result);
        end
        w_delta = i_now - n_since;
        if (n_left != '0 && w_delta >= TIME_BITS'(n_length)) begin
            n_led   = !n_led;
            n_since = i_now;
            if (!n_led) begin
                n_left = n_left - 3'd1;
            end
        end
    end

    assign o_led = n_led;

endmodule

>>> sv/tuner_start_sequencer_top.sv
// top level of the tuner start sequencer: poll stream in, action stream out
`timescale 1ns / 1ps

// usage
// - s_axis carries one poll per transaction: time in ms, pc message flag, transceiver
//   reply code and value, start request, jumper and key levels
// - m_axis returns exactly one result transaction per poll: forwarding flags, message
//   to send, restore flag, the saved transceiver settings, start pin, led, outcome
// - the cfg write channel sets the five millisecond timeouts by index; it is always
//   ready and is meant to be written only while no poll is in flight
// - an accepted poll goes into one input register, then through the sequencer and flasher
//   logic into the result register
// - throughput is one poll per cycle while the receiver takes results; the input register
//   advances whenever the result register is empty or being taken the same cycle
// - when the receiver stalls, the result holds and one more poll is buffered in the
//   input register, then s_axis_tready drops
// - reset (synchronous, active low) returns to idle with all timeouts at their
//   defaults, saved settings zero, start pin released and led off
// - TIME_BITS sets the width of the internal time arithmetic (16 to 64)
module tuner_start_sequencer_top
    import tss_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // now_ms[31:0], pc_message_valid[32], txr_reply[35:33], txr_value[45:36],
    // start_request[46], jump_low[47], key_low[48], zero[55:49]
    input  logic [55:0]              s_axis_tdata,

    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // forward_pc_to_txr[0], forward_txr_to_pc[1], send_code[4:2], restore_now[5],
    // saved_function[15:6], saved_mode[19:16], saved_meter[29:20],
    // saved_power[39:30], start_pin_low[40], led_on[41], outcome[43:42], zero[47:44]
    output logic [47:0]              m_axis_tdata,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg                 r_cfg;
    t_in_item             r_in;
    logic                 r_in_valid;
    t_out_item            r_out;
    logic                 r_out_valid;

    logic                 w_out_free;
    logic                 w_advance;
    logic [TIME_BITS-1:0] w_now;
    t_seq_out             w_seq;
    logic                 w_led;

    // ---------------- configuration registers ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reply_timeout_ms     <= RST_REPLY_TIMEOUT;
            r_cfg.start_timeout_ms     <= RST_START_TIMEOUT;
            r_cfg.tune_limit_ms        <= RST_TUNE_TIMEOUT;
            r_cfg.finish_wait_ms       <= RST_FINISH_WAIT;
            r_cfg.pulse_end_timeout_ms <= RST_PULSE_TIMEOUT;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_REPLY_TIMEOUT: r_cfg.reply_timeout_ms     <= i_cfg_data;
                CFG_START_TIMEOUT: r_cfg.start_timeout_ms     <= i_cfg_data;
                CFG_TUNE_TIMEOUT:  r_cfg.tune_limit_ms        <= i_cfg_data;
                CFG_FINISH_WAIT:   r_cfg.finish_wait_ms       <= i_cfg_data;
                CFG_PULSE_TIMEOUT: r_cfg.pulse_end_timeout_ms <= i_cfg_data;
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // payload only loads on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= t_in_item'(s_axis_tdata);
        end
    end

    // time is kept modulo 2^TIME_BITS
    assign w_now = TIME_BITS'(r_in.now_ms);

    // ---------------- poll processing ----------------
    tss_sequencer #(
        .TIME_BITS (TIME_BITS)
    ) u_sequencer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_item  (r_in),
        .i_now   (w_now),
        .i_cfg   (r_cfg),
        .o_seq   (w_seq)
    );

    tss_flasher #(
        .TIME_BITS (TIME_BITS)
    ) u_flasher (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_now    (w_now),
        .i_result (w_seq.result),
        .o_led    (w_led)
    );

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out.pad               <= '0;
            r_out.outcome           <= w_seq.result;
            r_out.led_on            <= w_led;
            r_out.start_pin_low     <= w_seq.start_low;
            r_out.saved_power       <= w_seq.keep_power;
            r_out.saved_meter       <= w_seq.keep_meter;
            r_out.saved_mode        <= w_seq.keep_mode;
            r_out.saved_function    <= w_seq.keep_function;
            r_out.restore_now       <= w_seq.restore;
            r_out.send_code         <= w_seq.send;
            r_out.forward_txr_to_pc <= w_seq.fwd_txr;
            r_out.forward_pc_to_txr <= w_seq.fwd_pc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef SYNTHESIS
    // an ending never sends a setup, query or key on
    a_outcome_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.outcome != OUT_NONE) |->
        (r_out.send_code == SEND_NONE || r_out.send_code == SEND_KEY_OFF))
        else $error("outcome reported together with a start-side message");

    // restoring settings only happens at an ending
    a_restore_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.restore_now) |-> (r_out.outcome != OUT_NONE))
        else $error("restore without an outcome");

    // the flasher starts with the led lit
    a_outcome_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.outcome != OUT_NONE) |-> r_out.led_on)
        else $error("outcome reported with led off");

    // tune setup goes out with the start line pulled low
    a_setup_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.send_code == SEND_SETUP) |-> r_out.start_pin_low)
        else $error("tune setup without start pin asserted");

    // a buffered poll is never dropped while the result stalls
    a_hold_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> r_in_valid)
        else $error("buffered poll lost during stall");
`endif

endmodule

>>> bench/tb_tuner_start_sequencer_top.sv
// self-checking bench for the tuner start sequencer: poll sessions checked against a predictor
`timescale 1ns / 1ps

module tb_tuner_start_sequencer_top;
    import tss_pkg::*;

    localparam int QUIET_LIMIT     = 2000;  // cycles with no transaction before giving up
    localparam int HOLD_AFTER      = 400;   // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 238;
    localparam int DRAIN_CYCLES    = 4;     // margin after the queues are empty

    // led flasher patterns per outcome
    localparam logic [2:0] FLASHES_SINGLE = 3'd1;
    localparam logic [2:0] FLASHES_ERROR  = 3'd5;
    localparam logic [9:0] FLASH_SHORT_MS = 10'd100;
    localparam logic [9:0] FLASH_LONG_MS  = 10'd1000;

    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic [55:0]              s_tdata   = '0;
    logic                     s_axis_tready;
    logic                     m_axis_tvalid;
    logic                     m_tready  = 1'b0;
    logic [47:0]              m_axis_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    always #4 i_clk = ~i_clk;

    tuner_start_sequencer_top #(
        .TIME_BITS(32)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // predictor state, mirrors the sequencer and flasher
    t_phase      seq_phase;
    logic [31:0] seq_deadline;
    logic [3:0]  seq_pending;
    logic [9:0]  kept_function;
    logic [3:0]  kept_mode;
    logic [9:0]  kept_meter;
    logic [9:0]  kept_power;
    logic        start_low;
    logic [2:0]  flash_left;
    logic        led_level;
    logic [31:0] flash_mark;
    logic [9:0]  flash_span;
    logic [15:0] timeout_ms [5];

    // stimulus and scoreboard
    t_in_item  polls_to_send [$];
    t_out_item expected_actions [$];
    logic [31:0] wall_ms;
    int  queued;
    int  mismatches   = 0;
    int  results_seen = 0;
    bit  idle_on      = 1'b1;
    bit  poll_taken   = 1'b0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    int  hold_left    = 0;
    bit  held_once    = 1'b0;

    // expected result of one poll, advancing the predictor state
    function automatic t_out_item next_actions(input t_in_item p);
        t_out_item   r;
        t_outcome    res;
        logic        late;
        logic [31:0] since;
        r    = '0;
        res  = OUT_NONE;
        late = p.now_ms > seq_deadline;  // compared without wrap
        case (seq_phase)
            PH_QUERY: begin
                case (p.txr_reply)
                    REP_FUNCTION: begin
                        kept_function  = p.txr_value;
                        seq_pending[0] = 1'b0;
                    end
                    REP_MODE: begin
                        kept_mode      = p.txr_value[3:0];
                        seq_pending[1] = 1'b0;
                    end
                    REP_METER: begin
                        kept_meter     = p.txr_value;
                        seq_pending[2] = 1'b0;
                    end
                    REP_POWER: begin
                        kept_power     = p.txr_value;
                        seq_pending[3] = 1'b0;
                    end
                    default: ;
                endcase
                if (seq_pending == '0) begin
                    r.send_code  = SEND_SETUP;
                    start_low    = 1'b1;
                    seq_phase    = PH_TSTART;
                    seq_deadline = p.now_ms + timeout_ms[CFG_START_TIMEOUT];
                end else if (late) begin
                    // settings incomplete, nothing to restore
                    res       = OUT_ERR;
                    seq_phase = PH_IDLE;
                end
            end
            PH_TSTART: begin
                if (p.key_low) begin
                    start_low    = 1'b0;
                    r.send_code  = SEND_KEY_ON;
                    seq_phase    = PH_TUNING;
                    seq_deadline = p.now_ms + timeout_ms[CFG_TUNE_TIMEOUT];
                end else if (late) begin
                    start_low     = 1'b0;
                    r.restore_now = 1'b1;
                    res           = OUT_ERR;
                    seq_phase     = PH_IDLE;
                end
            end
            PH_TUNING: begin
                if (!p.key_low) begin
                    r.send_code  = SEND_KEY_OFF;
                    seq_phase    = PH_FIN1;
                    seq_deadline = p.now_ms + timeout_ms[CFG_FINISH_WAIT];
                end else if (late) begin
                    r.send_code   = SEND_KEY_OFF;
                    r.restore_now = 1'b1;
                    res           = OUT_ERR;
                    seq_phase     = PH_IDLE;
                end
            end
            PH_FIN1: begin
                if (p.key_low) begin
                    seq_phase    = PH_FIN2;
                    seq_deadline = p.now_ms + timeout_ms[CFG_PULSE_TIMEOUT];
                end else if (late) begin
                    r.restore_now = 1'b1;
                    res           = OUT_OK;
                    seq_phase     = PH_IDLE;
                end
            end
            PH_FIN2: begin
                if (!p.key_low) begin
                    r.restore_now = 1'b1;
                    res           = OUT_FAIL;
                    seq_phase     = PH_IDLE;
                end else if (late) begin
                    r.restore_now = 1'b1;
                    res           = OUT_ERR;
                    seq_phase     = PH_IDLE;
                end
            end
            default: begin
                // idle: forward both ways, then maybe kick off the query
                r.forward_pc_to_txr = p.pc_message_valid;
                r.forward_txr_to_pc = p.txr_reply != REP_NONE;
                if (p.start_request || p.jump_low) begin
                    seq_phase    = PH_QUERY;
                    seq_deadline = p.now_ms + timeout_ms[CFG_REPLY_TIMEOUT];
                    seq_pending  = PEND_ALL;
                    r.send_code  = SEND_QUERY;
                end else begin
                    seq_phase = PH_IDLE;
                end
            end
        endcase

        if (res != OUT_NONE) begin
            case (res)
                OUT_OK: begin
                    flash_left = FLASHES_SINGLE;
                    flash_span = FLASH_SHORT_MS;
                end
                OUT_FAIL: begin
                    flash_left = FLASHES_SINGLE;
                    flash_span = FLASH_LONG_MS;
                end
                default: begin
                    flash_left = FLASHES_ERROR;
                    flash_span = FLASH_SHORT_MS;
                end
            endcase
            led_level  = 1'b1;
            flash_mark = p.now_ms;
        end

        if (flash_left != 0) begin
            since = p.now_ms - flash_mark;
            if (since >= flash_span) begin
                led_level  = ~led_level;
                flash_mark = p.now_ms;
                if (!led_level) flash_left = flash_left - 3'd1;
            end
        end

        r.saved_function = kept_function;
        r.saved_mode     = kept_mode;
        r.saved_meter    = kept_meter;
        r.saved_power    = kept_power;
        r.start_pin_low  = start_low;
        r.led_on         = led_level;
        r.outcome        = res;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] seen);
        if (want !== seen) begin
            $error("%s expected %0d got %0d", name, want, seen);
            mismatches++;
        end
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic coin();
        return $urandom_range(0, 1) == 1;
    endfunction

    // mostly short steps, now and then a long one
    function automatic logic [31:0] ms_step();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 400);
            1:       return 0;
            default: return $urandom_range(1, 30);
        endcase
    endfunction

    task automatic add_poll(input logic [31:0] now, input logic pcv, input logic [2:0] rep,
                            input logic [9:0] val, input logic sreq, input logic jump,
                            input logic key);
        t_in_item p;
        p                  = '0;
        p.now_ms           = now;
        p.pc_message_valid = pcv;
        p.txr_reply        = rep;
        p.txr_value        = val;
        p.start_request    = sreq;
        p.jump_low         = jump;
        p.key_low          = key;
        polls_to_send.push_back(p);
        queued++;
    endtask

    // poll in the middle of a session: triggers and replies are don't-care there
    task automatic busy_poll(input logic key);
        wall_ms += ms_step();
        add_poll(wall_ms, coin(), 3'($urandom_range(0, 5)), 10'($urandom_range(0, 999)),
                 coin(), coin(), key);
    endtask

    // poll without a start trigger
    task automatic idle_poll(input logic [31:0] step);
        wall_ms += step;
        add_poll(wall_ms, coin(), 3'($urandom_range(0, 5)), 10'($urandom_range(0, 999)),
                 1'b0, 1'b0, coin());
    endtask

    // move the clock beyond the wait that the given register guards
    task automatic pass_deadline(input t_cfg_idx idx);
        wall_ms += timeout_ms[idx] + 1 + $urandom_range(0, 20);
    endtask

    // one start request through to an ending, with random detours
    task automatic tuning_session();
        t_reply order [4];
        t_reply tmp;
        int     skip, n, i, j;
        order = '{REP_FUNCTION, REP_MODE, REP_METER, REP_POWER};
        if ($urandom_range(0, 14) == 0) wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
        repeat ($urandom_range(0, 3)) idle_poll(ms_step());

        // tuner command, jumper, or both
        n = $urandom_range(0, 2);
        wall_ms += ms_step();
        add_poll(wall_ms, coin(), 3'($urandom_range(0, 5)), 10'($urandom_range(0, 999)),
                 n != 1, n != 0, coin());

        // settings replies in any order, some chatter, sometimes one never comes
        for (i = 3; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        skip = -1;
        if ($urandom_range(0, 9) == 0) skip = $urandom_range(0, 3);
        for (i = 0; i < 4; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                wall_ms += ms_step();
                add_poll(wall_ms, coin(), coin() ? REP_OTHER : REP_NONE,
                         10'($urandom_range(0, 999)), coin(), coin(), coin());
            end
            if (i != skip) begin
                wall_ms += ms_step();
                add_poll(wall_ms, coin(), order[i], 10'($urandom_range(0, 999)),
                         coin(), coin(), coin());
            end
        end
        if (skip >= 0) begin
            pass_deadline(CFG_REPLY_TIMEOUT);
            add_poll(wall_ms, coin(), REP_NONE, 10'($urandom_range(0, 999)), 1'b0, 1'b0,
                     coin());
            return;
        end

        // tuner start, key should follow
        repeat ($urandom_range(0, 3)) busy_poll(1'b0);
        if ($urandom_range(0, 9) == 0) begin
            pass_deadline(CFG_START_TIMEOUT);
            busy_poll(1'b0);
            return;
        end
        busy_poll(1'b1);

        // tuning with key held
        repeat ($urandom_range(0, 4)) busy_poll(1'b1);
        if ($urandom_range(0, 9) == 0) begin
            pass_deadline(CFG_TUNE_TIMEOUT);
            busy_poll(1'b1);
            return;
        end
        busy_poll(1'b0);

        // success, failure pulse, or pulse that never ends
        case ($urandom_range(0, 2))
            0: begin
                repeat ($urandom_range(0, 2)) busy_poll(1'b0);
                pass_deadline(CFG_FINISH_WAIT);
                busy_poll(1'b0);
            end
            1: begin
                repeat ($urandom_range(0, 2)) busy_poll(1'b0);
                busy_poll(1'b1);
                repeat ($urandom_range(0, 3)) busy_poll(1'b1);
                busy_poll(1'b0);
            end
            default: begin
                busy_poll(1'b1);
                pass_deadline(CFG_PULSE_TIMEOUT);
                busy_poll(1'b1);
            end
        endcase

        // let the flasher run a while
        repeat ($urandom_range(1, 6)) idle_poll($urandom_range(20, 600));
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // nothing queued, nothing in flight, then the drain margin
    task automatic wait_drained();
        do @(posedge i_clk);
        while (polls_to_send.size() != 0 || s_tvalid || expected_actions.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- driver

    // offers the next poll once the current one is taken, with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || poll_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (polls_to_send.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (idle_on && hold_left == 0 && $urandom_range(0, 11) == 0) begin
                gap_left = $urandom_range(0, 17);
                s_tvalid <= 1'b0;
            end else begin
                s_tdata  <= polls_to_send.pop_front();
                s_tvalid <= 1'b1;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off that backs up the input
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (!held_once && results_seen >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 17);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        poll_taken = i_rst_n && s_tvalid && s_axis_tready;
        if (poll_taken) expected_actions.push_back(next_actions(t_in_item'(s_tdata)));

        if (i_rst_n && cfg_valid && o_cfg_ready && cfg_index <= CFG_PULSE_TIMEOUT)
            timeout_ms[cfg_index] = cfg_data;

        if (i_rst_n && m_axis_tvalid && m_tready) begin
            results_seen++;
            got = t_out_item'(m_axis_tdata);
            if (expected_actions.size() == 0) begin
                $error("result transaction with no poll waiting for it");
                mismatches++;
            end else begin
                want = expected_actions.pop_front();
                compare_field("forward_pc_to_txr", 32'(want.forward_pc_to_txr),
                              32'(got.forward_pc_to_txr));
                compare_field("forward_txr_to_pc", 32'(want.forward_txr_to_pc),
                              32'(got.forward_txr_to_pc));
                compare_field("send_code", 32'(want.send_code), 32'(got.send_code));
                compare_field("restore_now", 32'(want.restore_now), 32'(got.restore_now));
                compare_field("saved_function", 32'(want.saved_function),
                              32'(got.saved_function));
                compare_field("saved_mode", 32'(want.saved_mode), 32'(got.saved_mode));
                compare_field("saved_meter", 32'(want.saved_meter), 32'(got.saved_meter));
                compare_field("saved_power", 32'(want.saved_power), 32'(got.saved_power));
                compare_field("start_pin_low", 32'(want.start_pin_low),
                              32'(got.start_pin_low));
                compare_field("led_on", 32'(want.led_on), 32'(got.led_on));
                compare_field("outcome", 32'(want.outcome), 32'(got.outcome));
            end
        end
    end

    // watchdog on stretches without any transaction
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) ||
                (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        int          ph;
        int          r;
        logic [15:0] value;

        // predictor starts from the reset state
        seq_phase     = PH_IDLE;
        seq_deadline  = '0;
        seq_pending   = '0;
        kept_function = '0;
        kept_mode     = '0;
        kept_meter    = '0;
        kept_power    = '0;
        start_low     = 1'b0;
        flash_left    = '0;
        led_level     = 1'b0;
        flash_mark    = '0;
        flash_span    = '0;
        timeout_ms[CFG_REPLY_TIMEOUT] = RST_REPLY_TIMEOUT;
        timeout_ms[CFG_START_TIMEOUT] = RST_START_TIMEOUT;
        timeout_ms[CFG_TUNE_TIMEOUT]  = RST_TUNE_TIMEOUT;
        timeout_ms[CFG_FINISH_WAIT]   = RST_FINISH_WAIT;
        timeout_ms[CFG_PULSE_TIMEOUT] = RST_PULSE_TIMEOUT;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk with reset timeouts
        // idle forwarding, then a start on a poll that also forwards
        add_poll(32'd0, 1'b1, REP_FUNCTION, 10'd999, 1'b0, 1'b0, 1'b0);
        add_poll(32'd1, 1'b0, REP_OTHER, 10'd0, 1'b0, 1'b0, 1'b1);
        add_poll(32'd2, 1'b1, REP_POWER, 10'd512, 1'b1, 1'b0, 1'b0);
        // replies: function, other code ignored, mode keeps low bits, function again, meter, power
        add_poll(32'd3, 1'b0, REP_FUNCTION, 10'd999, 1'b0, 1'b0, 1'b0);
        add_poll(32'd4, 1'b1, REP_OTHER, 10'd123, 1'b1, 1'b1, 1'b1);
        add_poll(32'd5, 1'b0, REP_MODE, 10'd999, 1'b0, 1'b0, 1'b0);
        add_poll(32'd6, 1'b0, REP_FUNCTION, 10'd0, 1'b0, 1'b0, 1'b0);
        add_poll(32'd7, 1'b0, REP_METER, 10'd999, 1'b0, 1'b0, 1'b0);
        add_poll(32'd8, 1'b0, REP_POWER, 10'd512, 1'b0, 1'b0, 1'b0);
        // reply while waiting for the tuner is ignored, then key on / off
        add_poll(32'd9, 1'b1, REP_FUNCTION, 10'd5, 1'b1, 1'b1, 1'b0);
        add_poll(32'd10, 1'b0, REP_NONE, 10'd0, 1'b0, 1'b0, 1'b1);
        add_poll(32'd20, 1'b0, REP_NONE, 10'd0, 1'b0, 1'b0, 1'b1);
        add_poll(32'd30, 1'b0, REP_NONE, 10'd0, 1'b0, 1'b0, 1'b0);
        // no failure pulse: success with restore, one short flash
        add_poll(32'd200, 1'b0, REP_NONE, 10'd0, 1'b0, 1'b0, 1'b0);
        add_poll(32'd300, 1'b1, REP_NONE, 10'd0, 1'b0, 1'b0, 1'b0);
        // jumper start, query times out: error without restore, then the flashes
        add_poll(32'd301, 1'b0, REP_NONE, 10'd0, 1'b0, 1'b1, 1'b0);
        add_poll(32'd900, 1'b0, REP_METER, 10'd1, 1'b0, 1'b0, 1'b0);
        add_poll(32'd1000, 1'b0, REP_NONE, 10'd0, 1'b0, 1'b0, 1'b0);
        add_poll(32'd1100, 1'b0, REP_NONE, 10'd0, 1'b0, 1'b0, 1'b0);
        add_poll(32'd1200, 1'b0, REP_NONE, 10'd0, 1'b0, 1'b0, 1'b0);
        add_poll(32'd1300, 1'b0, REP_NONE, 10'd0, 1'b0, 1'b0, 1'b0);
        // start at the top of the clock: deadline wraps, times out at once
        add_poll(32'hFFFF_FFFF, 1'b1, REP_OTHER, 10'd999, 1'b1, 1'b1, 1'b1);
        add_poll(32'hFFFF_FFFF, 1'b0, REP_NONE, 10'd0, 1'b0, 1'b0, 1'b1);
        add_poll(32'd0, 1'b1, REP_NONE, 10'd0, 1'b0, 1'b0, 1'b0);
        wall_ms = 32'd5000;

        // phases: reset values, all zero, all max, small without idling, mixed, small without idling
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                wait_drained();
                for (r = int'(CFG_REPLY_TIMEOUT); r <= int'(CFG_PULSE_TIMEOUT); r++) begin
                    case (ph)
                        1:       value = 16'd0;
                        2:       value = 16'hFFFF;
                        4:       value = coin() ? 16'($urandom_range(0, 65535))
                                                : 16'($urandom_range(0, 300));
                        default: value = 16'($urandom_range(1, 300));
                    endcase
                    write_reg(t_cfg_idx'(3'(r)), value);
                end
            end
            idle_on = (ph != 3) && (ph != PHASES - 1);
            queued  = 0;
            while (queued < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 5) == 0)
                    add_poll($urandom(), coin(), 3'($urandom_range(0, 5)),
                             10'($urandom_range(0, 999)), coin(), coin(), coin());
                else
                    tuning_session();
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
